[sv/bounded_memory_bus_with_watch_trace_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef BOUNDED_MEMORY_BUS_WITH_WATCH_TRACE_MACROS_SVH
`define BOUNDED_MEMORY_BUS_WITH_WATCH_TRACE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BMB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BMB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[sv/bmbw_pkg.sv]
package bmbw_pkg;

    localparam int RAM_BYTES_DEF  = 1048576;
    localparam int FAULT_CAP_DEF  = 64;
    localparam int WWATCH_CAP_DEF = 512;
    localparam int RING_DEPTH_DEF = 4096;

    localparam int CFG_ADDR_W = 5;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_NONE = 2'd3;

    // which log a record request reads
    localparam logic [1:0] REC_NONE   = 2'd0;
    localparam logic [1:0] REC_FAULT  = 2'd1;
    localparam logic [1:0] REC_WWATCH = 2'd2;
    localparam logic [1:0] REC_RING   = 2'd3;

    typedef struct packed {
        logic [20:0] ram_in_use;
        logic [31:0] ww_low;
        logic [31:0] ww_high;
        logic [31:0] rw_low;
        logic [31:0] rw_high;
    } bmbw_cfg_t;

    typedef struct packed {
        logic        fault;
        logic        ram_wr;
        logic        ram_rd;
        logic        ww_hit;
        logic        rw_hit;
        logic        is_write;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] pc;
        logic [31:0] value;
        logic [1:0]  rec_sel;
        logic [11:0] rec_index;
    } bmbw_op_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] pc;
        logic [31:0] value;
        logic [1:0]  size;
        logic        was_write;
    } bmbw_rec_t;

endpackage

[sv/bmbw_cfg.sv]
module bmbw_cfg
    import bmbw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output bmbw_cfg_t             cfg
);

    localparam logic [2:0] REG_RAM_IN_USE = 3'd0;
    localparam logic [2:0] REG_WW_LOW     = 3'd1;
    localparam logic [2:0] REG_WW_HIGH    = 3'd2;
    localparam logic [2:0] REG_RW_LOW     = 3'd3;
    localparam logic [2:0] REG_RW_HIGH    = 3'd4;

    localparam logic [20:0] RAM_IN_USE_RST = 21'h10_0000;

    bmbw_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ram_in_use <= RAM_IN_USE_RST;
            cfg_reg.ww_low     <= '0;
            cfg_reg.ww_high    <= '0;
            cfg_reg.rw_low     <= '0;
            cfg_reg.rw_high    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RAM_IN_USE: cfg_reg.ram_in_use <= pwdata[20:0];
                REG_WW_LOW:     cfg_reg.ww_low     <= pwdata;
                REG_WW_HIGH:    cfg_reg.ww_high    <= pwdata;
                REG_RW_LOW:     cfg_reg.rw_low     <= pwdata;
                REG_RW_HIGH:    cfg_reg.rw_high    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RAM_IN_USE: prdata = {11'b0, cfg_reg.ram_in_use};
            REG_WW_LOW:     prdata = cfg_reg.ww_low;
            REG_WW_HIGH:    prdata = cfg_reg.ww_high;
            REG_RW_LOW:     prdata = cfg_reg.rw_low;
            REG_RW_HIGH:    prdata = cfg_reg.rw_high;
            default:        prdata = '0;
        endcase
    end

endmodule

[sv/bmbw_check.sv]
module bmbw_check
    import bmbw_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
)
(
    input  bmbw_cfg_t   cfg,
    input  logic [2:0]  req_type,
    input  logic [1:0]  access_size,
    input  logic [31:0] address,
    input  logic [31:0] write_data,
    input  logic [31:0] issuing_pc,
    input  logic [11:0] record_index,
    output bmbw_op_t    op
);

    localparam logic [2:0] REQ_READ       = 3'd0;
    localparam logic [2:0] REQ_WRITE      = 3'd1;
    localparam logic [2:0] REQ_FAULT_REC  = 3'd2;
    localparam logic [2:0] REQ_WWATCH_REC = 3'd3;
    localparam logic [2:0] REQ_RWATCH_REC = 3'd4;

    localparam logic [32:0] RamLimit = 33'(RAM_BYTES);

    logic [32:0] in_use;
    logic [32:0] limit;
    logic [32:0] acc_end;
    logic        is_mem;
    logic        is_write;
    logic        ok;

    always_comb begin
        in_use   = 33'(cfg.ram_in_use);
        limit    = (in_use < RamLimit) ? in_use : RamLimit;
        // end computed one bit wider so a wrap past 4G counts as a fault
        acc_end  = {1'b0, address} + (33'd1 << access_size);
        is_write = (req_type == REQ_WRITE);
        is_mem   = ((req_type == REQ_READ) || is_write) && (access_size != SIZE_NONE);
        ok       = is_mem && (acc_end <= limit);

        op           = '0;
        op.fault     = is_mem && (acc_end > limit);
        op.ram_wr    = ok && is_write;
        op.ram_rd    = ok && !is_write;
        op.ww_hit    = ok && is_write && (cfg.ww_high > cfg.ww_low)
                       && (acc_end > {1'b0, cfg.ww_low}) && (address < cfg.ww_high);
        op.rw_hit    = ok && !is_write && (cfg.rw_high > cfg.rw_low)
                       && (address >= cfg.rw_low) && (address < cfg.rw_high);
        op.is_write  = is_write;
        op.size      = access_size;
        op.addr      = address;
        op.pc        = issuing_pc;
        op.rec_index = record_index;

        case (access_size)
            SIZE_BYTE: op.value = {24'b0, write_data[7:0]};
            SIZE_WORD: op.value = {16'b0, write_data[15:0]};
            SIZE_LONG: op.value = write_data;
            default:   op.value = '0;
        endcase

        unique case (req_type)
            REQ_FAULT_REC:  op.rec_sel = REC_FAULT;
            REQ_WWATCH_REC: op.rec_sel = REC_WWATCH;
            REQ_RWATCH_REC: op.rec_sel = REC_RING;
            default:        op.rec_sel = REC_NONE;
        endcase
    end

endmodule

[sv/bmbw_ram.sv]
module bmbw_ram
    import bmbw_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
)
(
    input  logic        aclk,
    input  logic        en,
    input  bmbw_op_t    op,
    output logic [31:0] read_data
);

    localparam int Rows = (RAM_BYTES + 3) / 4;
    localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

    logic [RowW-1:0] row_base;
    logic [31:0]     bank_q;
    logic [1:0]      lane_reg;
    logic [1:0]      size_reg;
    logic            rd_reg;
    logic [31:0]     seq;
    logic [31:0]     rd_word;

    assign row_base = op.addr[RowW+1:2];

    // four byte lanes, one per address bit pattern [1:0]; an unaligned
    // access touches each lane at most once
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]      mem_reg [Rows];
        logic [7:0]      q_reg;
        logic [1:0]      offs;
        logic [RowW-1:0] row;
        logic            touch;
        logic [7:0]      wbyte;

        always_comb begin
            offs = 2'(b) - op.addr[1:0];
            row  = row_base + RowW'(2'(b) < op.addr[1:0]);
            case (op.size)
                SIZE_BYTE: touch = (offs == 2'd0);
                SIZE_WORD: touch = (offs <= 2'd1);
                default:   touch = 1'b1;
            endcase
            // big-endian: byte at offset 0 is the most significant
            case (op.size)
                SIZE_BYTE: wbyte = op.value[7:0];
                SIZE_WORD: wbyte = offs[0] ? op.value[7:0] : op.value[15:8];
                default:   wbyte = op.value[(5'd24 - {offs, 3'b000}) +: 8];
            endcase
        end

        always_ff @(posedge aclk) begin
            if (en && op.ram_wr && touch) begin
                mem_reg[row] <= wbyte;
            end
            if (en) begin
                q_reg <= mem_reg[row];
            end
        end

        assign bank_q[8*b +: 8] = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= op.addr[1:0];
            size_reg <= op.size;
            rd_reg   <= op.ram_rd;
        end
    end

    // rotate lanes so that seq[31:24] is the byte at the start address
    always_comb begin
        case (lane_reg)
            2'd0:    seq = {bank_q[7:0],   bank_q[15:8],  bank_q[23:16], bank_q[31:24]};
            2'd1:    seq = {bank_q[15:8],  bank_q[23:16], bank_q[31:24], bank_q[7:0]};
            2'd2:    seq = {bank_q[23:16], bank_q[31:24], bank_q[7:0],   bank_q[15:8]};
            default: seq = {bank_q[31:24], bank_q[7:0],   bank_q[15:8],  bank_q[23:16]};
        endcase
        case (size_reg)
            SIZE_BYTE: rd_word = {24'b0, seq[31:24]};
            SIZE_WORD: rd_word = {16'b0, seq[31:16]};
            default:   rd_word = seq;
        endcase
        read_data = rd_reg ? rd_word : '0;
    end

endmodule

[sv/bmbw_log.sv]
`include "bounded_memory_bus_with_watch_trace_macros.svh"

module bmbw_log
    import bmbw_pkg::*;
#(
    parameter int FAULT_CAP  = FAULT_CAP_DEF,
    parameter int WWATCH_CAP = WWATCH_CAP_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  bmbw_op_t    op,
    output logic [31:0] fault_total,
    output logic [31:0] wwatch_total,
    output logic [31:0] rwatch_total,
    output bmbw_rec_t   rec
);

    localparam int FaultW = (FAULT_CAP > 1) ? $clog2(FAULT_CAP) : 1;
    localparam int WwW    = (WWATCH_CAP > 1) ? $clog2(WWATCH_CAP) : 1;
    localparam int RingW  = $clog2(RING_DEPTH);

    localparam logic [31:0]      FaultCap = 32'(FAULT_CAP);
    localparam logic [31:0]      WwCap    = 32'(WWATCH_CAP);
    localparam logic [31:0]      RingCap  = 32'(RING_DEPTH);
    localparam logic [RingW-1:0] RingLast = RingW'(RING_DEPTH - 1);
    localparam logic [31:0]      SatMax   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] pc;
        logic [2:0]  kind;
    } fault_ent_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] pc;
        logic [31:0] value;
        logic [1:0]  size;
    } ww_ent_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] pc;
    } ring_ent_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == SatMax) ? c : c + 32'd1;
    endfunction

    fault_ent_t fault_mem_reg [FAULT_CAP];
    ww_ent_t    ww_mem_reg    [WWATCH_CAP];
    ring_ent_t  ring_mem_reg  [RING_DEPTH];

    fault_ent_t fault_q_reg;
    ww_ent_t    ww_q_reg;
    ring_ent_t  ring_q_reg;

    logic [31:0]      fault_cnt_reg;
    logic [31:0]      ww_cnt_reg;
    logic [31:0]      rw_cnt_reg;
    logic [RingW-1:0] ring_slot_reg;
    logic             ring_wrapped_reg;
    logic             rec_valid_reg;
    logic [1:0]       rec_sel_reg;
    logic [11:0]      rec_idx_reg;

    logic [31:0] idx32;
    logic        rec_valid_next;
    logic        fault_room;
    logic        ww_room;

    assign idx32      = 32'(op.rec_index);
    assign fault_room = (fault_cnt_reg < FaultCap);
    assign ww_room    = (ww_cnt_reg < WwCap);

    always_comb begin
        case (op.rec_sel)
            REC_FAULT:  rec_valid_next = (idx32 < FaultCap) && (idx32 < fault_cnt_reg);
            REC_WWATCH: rec_valid_next = (idx32 < WwCap) && (idx32 < ww_cnt_reg);
            REC_RING:   rec_valid_next = (idx32 < RingCap)
                                         && (ring_wrapped_reg || (idx32 < 32'(ring_slot_reg)));
            default:    rec_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_cnt_reg    <= '0;
            ww_cnt_reg       <= '0;
            rw_cnt_reg       <= '0;
            ring_slot_reg    <= '0;
            ring_wrapped_reg <= 1'b0;
            rec_valid_reg    <= 1'b0;
            rec_sel_reg      <= REC_NONE;
        end else if (en) begin
            if (op.fault) begin
                fault_cnt_reg <= sat_inc(fault_cnt_reg);
            end
            if (op.ww_hit) begin
                ww_cnt_reg <= sat_inc(ww_cnt_reg);
            end
            if (op.rw_hit) begin
                rw_cnt_reg <= sat_inc(rw_cnt_reg);
                // the ring keeps wrapping after the count saturates
                if (ring_slot_reg == RingLast) begin
                    ring_slot_reg    <= '0;
                    ring_wrapped_reg <= 1'b1;
                end else begin
                    ring_slot_reg <= ring_slot_reg + 1'b1;
                end
            end
            rec_valid_reg <= rec_valid_next;
            rec_sel_reg   <= op.rec_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && op.fault && fault_room) begin
            fault_mem_reg[fault_cnt_reg[FaultW-1:0]] <= '{addr: op.addr, pc: op.pc,
                                                         kind: {op.is_write, op.size}};
        end
        if (en && op.ww_hit && ww_room) begin
            ww_mem_reg[ww_cnt_reg[WwW-1:0]] <= '{addr: op.addr, pc: op.pc,
                                                 value: op.value, size: op.size};
        end
        if (en && op.rw_hit) begin
            ring_mem_reg[ring_slot_reg] <= '{addr: op.addr, pc: op.pc};
        end
        if (en) begin
            fault_q_reg <= fault_mem_reg[idx32[FaultW-1:0]];
            ww_q_reg    <= ww_mem_reg[idx32[WwW-1:0]];
            ring_q_reg  <= ring_mem_reg[idx32[RingW-1:0]];
            rec_idx_reg <= op.rec_index;
        end
    end

    assign fault_total  = fault_cnt_reg;
    assign wwatch_total = ww_cnt_reg;
    assign rwatch_total = rw_cnt_reg;

    always_comb begin
        rec = '0;
        if (rec_valid_reg) begin
            case (rec_sel_reg)
                REC_FAULT: begin
                    rec.valid     = 1'b1;
                    rec.addr      = fault_q_reg.addr;
                    rec.pc        = fault_q_reg.pc;
                    rec.size      = fault_q_reg.kind[1:0];
                    rec.was_write = fault_q_reg.kind[2];
                end
                REC_WWATCH: begin
                    rec.valid = 1'b1;
                    rec.addr  = ww_q_reg.addr;
                    rec.pc    = ww_q_reg.pc;
                    rec.value = ww_q_reg.value;
                    rec.size  = ww_q_reg.size;
                end
                REC_RING: begin
                    rec.valid = 1'b1;
                    rec.addr  = ring_q_reg.addr;
                    rec.pc    = ring_q_reg.pc;
                end
                default: ;
            endcase
        end
    end

    `BMB_ASSERT_IMPL(fault_rec_written, aclk, aresetn,
        rec_valid_reg && (rec_sel_reg == REC_FAULT), 32'(rec_idx_reg) < fault_cnt_reg,
        "fault record slot was never written")
    `BMB_ASSERT_IMPL(wwatch_rec_written, aclk, aresetn,
        rec_valid_reg && (rec_sel_reg == REC_WWATCH), 32'(rec_idx_reg) < ww_cnt_reg,
        "write-watch record slot was never written")
    `BMB_ASSERT_IMPL(ring_slot_tracks_count, aclk, aresetn,
        !ring_wrapped_reg, rw_cnt_reg == 32'(ring_slot_reg),
        "ring slot and read-watch count disagree before wrap")

endmodule

[sv/bounded_memory_bus_with_watch_trace.sv]
// memory bus monitor with fault log, write-watch log and read-watch ring
//
// s_ channel: one request word per handshake; req_type in s_tuser selects a
// memory read or write (byte, word or long, big-endian, any alignment) or a
// read-back of one slot of the fault log, the write-watch log or the ring.
// m_ channel: exactly one result word per request, in request order.
// apb port: five 32-bit registers at byte addresses 0, 4, 8, 12, 16;
// write them only while no request is in flight.
//
// throughput: one request per cycle while the output is not stalled; every ram lane
// and every log takes at most one write and one registered read per request,
// counters update in the same cycle. a request reaches its result word through
// the input register, then the memory read register.
// reset clears the counters, the ring pointer and the pipeline valids;
// ram and log contents stay undefined, and slots are reported valid only
// once written, so no clearing pass is needed.
// when m_tready is low the result stage holds, the input stage still takes
// one more word, then s_tready drops until the output drains.
`include "bounded_memory_bus_with_watch_trace_macros.svh"

module bounded_memory_bus_with_watch_trace
    import bmbw_pkg::*;
#(
    parameter int RAM_BYTES  = RAM_BYTES_DEF,
    parameter int FAULT_CAP  = FAULT_CAP_DEF,
    parameter int WWATCH_CAP = WWATCH_CAP_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // access_size, address, write_data, issuing_pc, record_index, pad
    input  logic [111:0]          s_tdata,
    // req_type
    input  logic [2:0]            s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data, watch_hit, fault_total, write_watch_total, read_watch_total,
    // record_address, record_pc, record_value, record_size, record_was_write, pad
    output logic [231:0]          m_tdata,
    // fault, record_valid
    output logic [1:0]            m_tuser,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    bmbw_cfg_t cfg;
    bmbw_op_t  op;
    bmbw_rec_t rec;

    logic        a_valid_reg;
    logic [2:0]  a_type_reg;
    logic [1:0]  a_size_reg;
    logic [31:0] a_addr_reg;
    logic [31:0] a_wdata_reg;
    logic [31:0] a_pc_reg;
    logic [11:0] a_idx_reg;

    logic        b_valid_reg;
    logic        b_fault_reg;
    logic        b_watch_reg;

    logic        b_free;
    logic        a_move;
    logic [31:0] ram_rdata;
    logic [31:0] fault_total;
    logic [31:0] wwatch_total;
    logic [31:0] rwatch_total;

    assign b_free   = !b_valid_reg || m_tready;
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_type_reg  <= s_tuser;
            a_size_reg  <= s_tdata[1:0];
            a_addr_reg  <= s_tdata[33:2];
            a_wdata_reg <= s_tdata[65:34];
            a_pc_reg    <= s_tdata[97:66];
            a_idx_reg   <= s_tdata[109:98];
        end
        if (a_move) begin
            b_fault_reg <= op.fault;
            b_watch_reg <= op.ww_hit | op.rw_hit;
        end
    end

    bmbw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmbw_check #(
        .RAM_BYTES (RAM_BYTES)
    ) u_check (
        .cfg          (cfg),
        .req_type     (a_type_reg),
        .access_size  (a_size_reg),
        .address      (a_addr_reg),
        .write_data   (a_wdata_reg),
        .issuing_pc   (a_pc_reg),
        .record_index (a_idx_reg),
        .op           (op)
    );

    bmbw_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .aclk      (aclk),
        .en        (a_move),
        .op        (op),
        .read_data (ram_rdata)
    );

    bmbw_log #(
        .FAULT_CAP  (FAULT_CAP),
        .WWATCH_CAP (WWATCH_CAP),
        .RING_DEPTH (RING_DEPTH)
    ) u_log (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (a_move),
        .op           (op),
        .fault_total  (fault_total),
        .wwatch_total (wwatch_total),
        .rwatch_total (rwatch_total),
        .rec          (rec)
    );

    assign m_tvalid = b_valid_reg;
    assign m_tuser  = {rec.valid, b_fault_reg};
    assign m_tdata  = {4'b0, rec.was_write, rec.size, rec.value, rec.pc, rec.addr,
                       rwatch_total, wwatch_total, fault_total, b_watch_reg, ram_rdata};

    `BMB_ASSERT_IMPL(fault_excludes_watch, aclk, aresetn,
        b_valid_reg && b_fault_reg, !b_watch_reg && (ram_rdata == 32'd0),
        "faulting access shows a watch hit or read data")
    `BMB_ASSERT_NEXT(fault_reaches_output, aclk, aresetn,
        a_move && op.fault, b_valid_reg && b_fault_reg,
        "fault lost between check and result stage")
    `BMB_ASSERT_IMPL(record_not_memory, aclk, aresetn,
        b_valid_reg && rec.valid, !b_fault_reg && !b_watch_reg,
        "record read-back carries memory access flags")

endmodule

[tb/sv/bounded_memory_bus_with_watch_trace_tb.sv]
`timescale 1ns / 100ps

import bmbw_pkg::*;

typedef enum logic [2:0] {
    REQ_READ       = 3'd0,
    REQ_WRITE      = 3'd1,
    REQ_FAULT_LOG  = 3'd2,
    REQ_WWATCH_LOG = 3'd3,
    REQ_RING_LOG   = 3'd4,
    REQ_UNUSED_LO  = 3'd5,
    REQ_UNUSED_HI  = 3'd7
} req_kind_e;

typedef enum int {
    REG_RAM_IN_USE = 0,
    REG_WW_LOW     = 1,
    REG_WW_HIGH    = 2,
    REG_RW_LOW     = 3,
    REG_RW_HIGH    = 4
} cfg_reg_e;

typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] pc;
    logic [11:0] slot;
} bus_req_t;

typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
    logic        watch_hit;
    logic [31:0] fault_total;
    logic [31:0] ww_total;
    logic [31:0] rw_total;
    logic        rec_valid;
    logic [31:0] rec_addr;
    logic [31:0] rec_pc;
    logic [31:0] rec_value;
    logic [1:0]  rec_size;
    logic        rec_was_write;
} bus_res_t;

class bus_watch_predictor;
    logic [20:0] ram_in_use = 21'(RAM_BYTES_DEF);
    logic [31:0] ww_low = '0;
    logic [31:0] ww_high = '0;
    logic [31:0] rw_low = '0;
    logic [31:0] rw_high = '0;

    logic [7:0]  ram_img [bit [31:0]];
    logic [31:0] written_bases [$];

    logic [31:0] flt_addr [FAULT_CAP_DEF];
    logic [31:0] flt_pc [FAULT_CAP_DEF];
    logic [1:0]  flt_size [FAULT_CAP_DEF];
    logic        flt_write [FAULT_CAP_DEF];
    logic [31:0] fault_count = '0;

    logic [31:0] wlog_addr [WWATCH_CAP_DEF];
    logic [31:0] wlog_pc [WWATCH_CAP_DEF];
    logic [31:0] wlog_value [WWATCH_CAP_DEF];
    logic [1:0]  wlog_size [WWATCH_CAP_DEF];
    logic [31:0] ww_count = '0;

    logic [31:0] ring_addr [RING_DEPTH_DEF];
    logic [31:0] ring_pc [RING_DEPTH_DEF];
    logic [31:0] rw_count = '0;
    int          ring_next = 0;
    bit          ring_full = 1'b0;

    bus_res_t    pending_results [$];
    int          mismatches = 0;

    function void write_reg(cfg_reg_e idx, logic [31:0] v);
        case (idx)
            REG_RAM_IN_USE: ram_in_use = v[20:0];
            REG_WW_LOW:     ww_low = v;
            REG_WW_HIGH:    ww_high = v;
            REG_RW_LOW:     rw_low = v;
            REG_RW_HIGH:    rw_high = v;
            default: ;
        endcase
    endfunction

    function logic [63:0] ram_limit();
        return (ram_in_use < RAM_BYTES_DEF) ? 64'(ram_in_use) : 64'(RAM_BYTES_DEF);
    endfunction

    function logic [31:0] bump(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // a read is fine when it faults or every byte it covers was written
    function bit read_is_safe(logic [31:0] a, logic [1:0] size);
        int n;
        n = 1 << size;
        if ({32'd0, a} + 64'(n) > ram_limit())
            return 1'b1;
        for (int i = 0; i < n; i++) begin
            if (!ram_img.exists(a + 32'(i)))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function void take_request(bus_req_t r);
        bus_res_t    o;
        int          n;
        logic [63:0] span_end;
        logic [31:0] mv;
        logic [31:0] rd;
        o = '0;
        n = 1 << r.size;
        span_end = {32'd0, r.addr} + 64'(n);
        if (r.kind <= REQ_WRITE && r.size != SIZE_NONE) begin
            if (span_end > ram_limit()) begin
                if (fault_count < FAULT_CAP_DEF) begin
                    flt_addr[fault_count] = r.addr;
                    flt_pc[fault_count] = r.pc;
                    flt_size[fault_count] = r.size;
                    flt_write[fault_count] = (r.kind == REQ_WRITE);
                end
                fault_count = bump(fault_count);
                o.fault = 1'b1;
            end else if (r.kind == REQ_WRITE) begin
                mv = (n == 4) ? r.wdata : r.wdata & ((32'd1 << (8 * n)) - 32'd1);
                // overlap test on the whole written span
                if (ww_high > ww_low && span_end > {32'd0, ww_low} && r.addr < ww_high) begin
                    if (ww_count < WWATCH_CAP_DEF) begin
                        wlog_addr[ww_count] = r.addr;
                        wlog_pc[ww_count] = r.pc;
                        wlog_value[ww_count] = mv;
                        wlog_size[ww_count] = r.size;
                    end
                    ww_count = bump(ww_count);
                    o.watch_hit = 1'b1;
                end
                for (int i = 0; i < n; i++)
                    ram_img[r.addr + 32'(i)] = 8'(mv >> (8 * (n - 1 - i)));
                written_bases.push_back(r.addr);
            end else begin
                if (rw_high > rw_low && r.addr >= rw_low && r.addr < rw_high) begin
                    ring_addr[ring_next] = r.addr;
                    ring_pc[ring_next] = r.pc;
                    ring_next++;
                    if (ring_next >= RING_DEPTH_DEF) begin
                        ring_next = 0;
                        ring_full = 1'b1;
                    end
                    rw_count = bump(rw_count);
                    o.watch_hit = 1'b1;
                end
                rd = '0;
                for (int i = 0; i < n; i++) begin
                    rd = rd << 8;
                    if (ram_img.exists(r.addr + 32'(i)))
                        rd[7:0] = ram_img[r.addr + 32'(i)];
                end
                o.read_data = rd;
            end
        end else if (r.kind == REQ_FAULT_LOG) begin
            if (r.slot < FAULT_CAP_DEF && r.slot < fault_count) begin
                o.rec_valid = 1'b1;
                o.rec_addr = flt_addr[r.slot];
                o.rec_pc = flt_pc[r.slot];
                o.rec_size = flt_size[r.slot];
                o.rec_was_write = flt_write[r.slot];
            end
        end else if (r.kind == REQ_WWATCH_LOG) begin
            if (r.slot < WWATCH_CAP_DEF && r.slot < ww_count) begin
                o.rec_valid = 1'b1;
                o.rec_addr = wlog_addr[r.slot];
                o.rec_pc = wlog_pc[r.slot];
                o.rec_value = wlog_value[r.slot];
                o.rec_size = wlog_size[r.slot];
            end
        end else if (r.kind == REQ_RING_LOG) begin
            // ring keeps no size, every slot is live once it has wrapped
            if (r.slot < RING_DEPTH_DEF && (ring_full || r.slot < ring_next)) begin
                o.rec_valid = 1'b1;
                o.rec_addr = ring_addr[r.slot];
                o.rec_pc = ring_pc[r.slot];
            end
        end
        o.fault_total = fault_count;
        o.ww_total = ww_count;
        o.rw_total = rw_count;
        pending_results.push_back(o);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %h got %h", $time, name, exp, act);
            mismatches++;
        end
    endfunction

    function void check_result(logic [231:0] d, logic [1:0] u);
        bus_res_t exp;
        if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected, got %h / %h", $time, d, u);
            mismatches++;
            return;
        end
        exp = pending_results.pop_front();
        check_field("read_data", exp.read_data, d[31:0]);
        check_field("watch_hit", 32'(exp.watch_hit), 32'(d[32]));
        check_field("fault_total", exp.fault_total, d[64:33]);
        check_field("write_watch_total", exp.ww_total, d[96:65]);
        check_field("read_watch_total", exp.rw_total, d[128:97]);
        check_field("record_address", exp.rec_addr, d[160:129]);
        check_field("record_pc", exp.rec_pc, d[192:161]);
        check_field("record_value", exp.rec_value, d[224:193]);
        check_field("record_size", 32'(exp.rec_size), 32'(d[226:225]));
        check_field("record_was_write", 32'(exp.rec_was_write), 32'(d[227]));
        check_field("fault", 32'(exp.fault), 32'(u[0]));
        check_field("record_valid", 32'(exp.rec_valid), 32'(u[1]));
    endfunction
endclass

module bounded_memory_bus_with_watch_trace_tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WIN_SPAN     = 256;
    localparam int PHASE_ITEMS  = 150;
    localparam int FILL_ITEMS   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [111:0]          s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [231:0]          m_tdata;
    logic [1:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int          send_gap_pct = 20;
    int          sink_stall_pct = 59;
    int          quiet_cycles = 0;
    logic [31:0] win_base = '0;

    bus_watch_predictor book = new();

    bounded_memory_bus_with_watch_trace DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bus_req_t bus_item(logic [2:0] kind, logic [1:0] size,
                                          logic [31:0] addr, logic [31:0] wdata,
                                          logic [31:0] pc, logic [11:0] slot);
        bus_req_t r;
        r.kind = kind;
        r.size = size;
        r.addr = addr;
        r.wdata = wdata;
        r.pc = pc;
        r.slot = slot;
        return r;
    endfunction

    task automatic send_request(input bus_req_t r);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.slot, r.pc, r.wdata, r.addr, r.size};
        s_tuser <= r.kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        book.take_request(r);
    endtask

    // wait until every expected word is back and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input cfg_reg_e idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4 * idx);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        book.write_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] lim, input logic [31:0] wl,
                              input logic [31:0] wh, input logic [31:0] rl,
                              input logic [31:0] rh);
        settle();
        apb_write(REG_RAM_IN_USE, lim);
        apb_write(REG_WW_LOW, wl);
        apb_write(REG_WW_HIGH, wh);
        apb_write(REG_RW_LOW, rl);
        apb_write(REG_RW_HIGH, rh);
    endtask

    function automatic logic [31:0] pick_addr(bit known_only);
        int sel;
        sel = $urandom_range(0, 99);
        if ((known_only || sel < 45) && book.written_bases.size() > 0)
            return book.written_bases[$urandom_range(0, book.written_bases.size() - 1)];
        else if (sel < 80)
            return win_base + 32'($urandom_range(0, WIN_SPAN - 1));
        else if (sel < 90)
            return 32'(book.ram_limit() - 64'($urandom_range(0, 4)));
        else if (sel < 95)
            return 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
        else
            return $urandom;
    endfunction

    function automatic logic [11:0] pick_slot();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 12'($urandom_range(0, 70));
        else if (sel < 70)
            return 12'($urandom_range(500, 520));
        else
            return 12'($urandom_range(0, 4095));
    endfunction

    task automatic send_random(input int count, input bit fill);
        bus_req_t r;
        int       sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            r.pc = $urandom;
            r.wdata = $urandom;
            r.slot = pick_slot();
            r.size = 2'($urandom_range(SIZE_BYTE, SIZE_LONG));
            if (fill)
                sel = (sel < 80) ? 0 : (sel < 95) ? 40 : 80;
            if (sel < 35) begin
                r.kind = REQ_READ;
                r.addr = pick_addr(fill);
                if (!book.read_is_safe(r.addr, r.size))
                    r.kind = REQ_WRITE;
            end else if (sel < 70) begin
                r.kind = REQ_WRITE;
                r.addr = pick_addr(1'b0);
            end else if (sel < 90) begin
                r.kind = 3'($urandom_range(REQ_FAULT_LOG, REQ_RING_LOG));
                r.addr = $urandom;
            end else if (sel < 95) begin
                // size code three is ignored by reads and writes alike
                r.kind = 3'($urandom_range(REQ_READ, REQ_WRITE));
                r.size = SIZE_NONE;
                r.addr = $urandom;
            end else begin
                r.kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                r.size = 2'($urandom_range(0, 3));
                r.addr = $urandom;
            end
            send_request(r);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: full ram, both watches off
        send_request(bus_item(REQ_WRITE, SIZE_LONG, 32'h0, 32'h0102_0304, 32'h0, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_WORD, 32'h6, 32'hFFFF_FFFF, 32'h10, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_BYTE, 32'h5, 32'hFFFF_FF5A, 32'h14, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_LONG, 32'h0, 32'h0, 32'h18, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_WORD, 32'h5, 32'h0, 32'h1C, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_LONG, RAM_BYTES_DEF - 4, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 12'hFFF));
        send_request(bus_item(REQ_READ, SIZE_LONG, RAM_BYTES_DEF - 4, 32'h0, 32'h20, 12'h0));
        // just past the end of ram, then ends that pass the top of the address space
        send_request(bus_item(REQ_READ, SIZE_WORD, RAM_BYTES_DEF - 1, 32'h0, 32'h24, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_BYTE, RAM_BYTES_DEF, 32'hA5, 32'h28, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_LONG, 32'hFFFF_FFFE, 32'h1234_5678,
                              32'h2C, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0, 32'h30, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_NONE, 32'h0, 32'h0, 32'h34, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_NONE, 32'h0, 32'hDEAD_BEEF, 32'h38, 12'h0));
        send_request(bus_item(REQ_UNUSED_LO, SIZE_BYTE, 32'h0, 32'h0, 32'h3C, 12'h0));
        send_request(bus_item(REQ_UNUSED_HI, SIZE_LONG, 32'h4, 32'h0, 32'h40, 12'h1));
        send_request(bus_item(REQ_FAULT_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h44, 12'h0));
        send_request(bus_item(REQ_FAULT_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h48, 12'h4));
        send_request(bus_item(REQ_FAULT_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h4C, 12'hFFF));
        send_request(bus_item(REQ_WWATCH_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h50, 12'h0));

        // narrow watches around the bytes written above
        set_config(RAM_BYTES_DEF, 32'h6, 32'h8, 32'h5, 32'h7);
        send_request(bus_item(REQ_WRITE, SIZE_WORD, 32'h4, 32'h0000_ABCD, 32'h54, 12'h0));
        send_request(bus_item(REQ_WRITE, SIZE_BYTE, 32'h7, 32'h0000_0077, 32'h58, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_LONG, 32'h4, 32'h0, 32'h5C, 12'h0));
        send_request(bus_item(REQ_READ, SIZE_BYTE, 32'h6, 32'h0, 32'h60, 12'h0));
        send_request(bus_item(REQ_WWATCH_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h64, 12'h0));
        send_request(bus_item(REQ_RING_LOG, SIZE_BYTE, 32'h0, 32'h0, 32'h68, 12'h0));

        win_base = RAM_BYTES_DEF - 200;
        set_config(RAM_BYTES_DEF, win_base + 16, win_base + 80, win_base + 40,
                   win_base + 200);
        send_random(PHASE_ITEMS, 1'b0);
        // oversized limit acts as the full ram; equal and inverted bounds disable
        set_config(32'h001F_FFFF, win_base, win_base, win_base + 100, win_base + 20);
        send_random(PHASE_ITEMS, 1'b0);

        send_gap_pct = 59;
        sink_stall_pct = 20;
        win_base = 32'h0;
        set_config(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h80);
        send_random(PHASE_ITEMS, 1'b0);
        win_base = 4099 - 200;
        set_config(4099, win_base + 100, win_base + 300, win_base, win_base + 256);
        send_random(PHASE_ITEMS, 1'b0);

        send_gap_pct = 0;
        sink_stall_pct = 0;
        win_base = 32'h0;
        set_config(17, 32'h3, 32'h9, 32'h0, 32'h11);
        send_random(PHASE_ITEMS, 1'b0);
        win_base = 65537 - 200;
        set_config(65537, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_random(PHASE_ITEMS, 1'b0);

        // watch everything, mostly reads of bytes already written
        win_base = 32'h800;
        set_config(RAM_BYTES_DEF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_random(FILL_ITEMS, 1'b1);

        settle();
        if (book.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[bounded_memory_bus_with_watch_trace.f]
+incdir+sv
sv/bmbw_pkg.sv
sv/bmbw_cfg.sv
sv/bmbw_check.sv
sv/bmbw_ram.sv
sv/bmbw_log.sv
sv/bounded_memory_bus_with_watch_trace.sv
tb/sv/bounded_memory_bus_with_watch_trace_tb.sv
